// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the sparse tile pattern unit.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define STP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define STP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/stp_pkg.sv -----
// Package of the sparse tile pattern unit: widths, codes, item and result types.
// No dependencies; used by every module of the block.
package stp_pkg;

  localparam int unsigned DW            = 16;
  localparam int unsigned MAX_TILE_COLS = 32;
  localparam int unsigned TCW           = $clog2(MAX_TILE_COLS);
  localparam int unsigned DCW           = $clog2(DW);
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QAW           = $clog2(QDEPTH);
  localparam int unsigned ODEPTH        = 4;
  localparam int unsigned OAW           = $clog2(ODEPTH);
  localparam logic [DW:0] NONE17        = {(DW+1){1'b1}};

  typedef enum logic [1:0] {
    REG_TILE_HEIGHT = 2'd0,
    REG_TILE_WIDTH  = 2'd1
  } reg_idx_t;

  typedef enum logic {
    OP_ENTRY  = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_st_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_APPLY
  } back_st_t;

  // Classified item handed from front to back.
  typedef struct packed {
    op_t              op;
    logic [DW-1:0]    row;
    logic [DW-1:0]    col;
    logic [TCW-1:0]   tc;
    logic [DW-1:0]    brs;
    logic [DW-1:0]    col_base;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] tile_row_start;
    logic [DW-1:0] tile_col_start;
    logic [DW-1:0] band_start;
    logic          is_upper;
    logic          last_of_burst;
  } res_t;

  // Handshake between the item queue and its neighbors.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_sts_t;

endpackage

// ----- rtl/core/stp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on stp_pkg for the data width.
module stp_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [stp_pkg::DW-1:0]   dividend,
  input  logic [stp_pkg::DW-1:0]   divisor,
  output logic                     busy,
  output logic [stp_pkg::DW-1:0]   quo,
  output logic [stp_pkg::DW-1:0]   rem
);

  logic                      busy_r;
  logic [stp_pkg::DCW-1:0]   cnt_r;
  logic [stp_pkg::DW:0]      rem_r;
  logic [stp_pkg::DW-1:0]    quo_r;
  logic [stp_pkg::DW-1:0]    div_r;
  logic [stp_pkg::DW:0]      trial;
  logic                      fits;

  assign trial = {rem_r[stp_pkg::DW-1:0], quo_r[stp_pkg::DW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == stp_pkg::DCW'(stp_pkg::DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, div_r}) : trial;
      quo_r <= {quo_r[stp_pkg::DW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r[stp_pkg::DW-1:0];

endmodule

// ----- rtl/core/stp_front.sv -----
// Front end: accepts items, divides row and column by the tile size, drops
// out-of-range columns and pushes classified items. Uses stp_pkg and stp_div.
module stp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_operation,
  input  logic [stp_pkg::DW-1:0]  in_entry_row,
  input  logic [stp_pkg::DW-1:0]  in_entry_col,
  input  logic [stp_pkg::DW-1:0]  eff_h,
  input  logic [stp_pkg::DW-1:0]  eff_w,
  input  stp_pkg::q_sts_t         q_sts,
  output logic                    q_push,
  output stp_pkg::item_t          q_item
);

  stp_pkg::front_st_t        st_r, st_nxt;
  stp_pkg::item_t            item_r;
  logic                      accept;
  logic                      div_start;
  logic                      col_busy, row_busy;
  logic [stp_pkg::DW-1:0]    col_quo, col_rem, row_quo, row_rem;
  logic                      in_range;

  assign accept    = in_push && (st_r == stp_pkg::F_IDLE);
  assign div_start = accept && (in_operation == stp_pkg::OP_ENTRY);
  assign in_range  = col_quo < stp_pkg::DW'(stp_pkg::MAX_TILE_COLS);

  stp_div u_col_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(in_entry_col), .divisor(eff_w),
    .busy(col_busy), .quo(col_quo), .rem(col_rem)
  );

  stp_div u_row_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(in_entry_row), .divisor(eff_h),
    .busy(row_busy), .quo(row_quo), .rem(row_rem)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      stp_pkg::F_IDLE: begin
        if (accept) begin
          st_nxt = (in_operation == stp_pkg::OP_FINISH) ? stp_pkg::F_PUSH : stp_pkg::F_DIV;
        end
      end
      stp_pkg::F_DIV: begin
        if (!col_busy && !row_busy) begin
          st_nxt = in_range ? stp_pkg::F_PUSH : stp_pkg::F_IDLE;
        end
      end
      stp_pkg::F_PUSH: begin
        if (!q_sts.full) begin
          st_nxt = stp_pkg::F_IDLE;
        end
      end
      default: st_nxt = stp_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_full = 1'b1;
    q_push  = 1'b0;
    case (st_r)
      stp_pkg::F_IDLE: in_full = 1'b0;
      stp_pkg::F_PUSH: q_push  = !q_sts.full;
      default: begin
        in_full = 1'b1;
        q_push  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= stp_pkg::F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Capture the raw item, then fill in tile column, block start and column base.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op       <= stp_pkg::op_t'(in_operation);
      item_r.row      <= in_entry_row;
      item_r.col      <= in_entry_col;
      item_r.tc       <= '0;
      item_r.brs      <= '0;
      item_r.col_base <= '0;
    end else if (st_r == stp_pkg::F_DIV && !col_busy && !row_busy) begin
      item_r.tc       <= col_quo[stp_pkg::TCW-1:0];
      item_r.brs      <= item_r.row - row_rem;
      item_r.col_base <= item_r.col - col_rem;
    end
  end

  assign q_item = item_r;

endmodule

// ----- rtl/core/stp_queue.sv -----
// Short item queue between front and back.
// Depends on stp_pkg for the item type and depth.
module stp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  stp_pkg::q_ctl_t  ctl,
  input  stp_pkg::item_t   wr_item,
  output stp_pkg::q_sts_t  sts,
  output stp_pkg::item_t   rd_item
);

  stp_pkg::item_t            mem_r [stp_pkg::QDEPTH];
  logic [stp_pkg::QAW-1:0]   wp_r, rp_r;
  logic [stp_pkg::QAW:0]     cnt_r;
  logic                      do_push, do_pop;

  assign do_push = ctl.push && (cnt_r != (stp_pkg::QAW+1)'(stp_pkg::QDEPTH));
  assign do_pop  = ctl.pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (stp_pkg::QAW+1)'(do_push) - (stp_pkg::QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_item;
  end

  assign sts.full  = cnt_r == (stp_pkg::QAW+1)'(stp_pkg::QDEPTH);
  assign sts.valid = cnt_r != '0;
  assign rd_item   = mem_r[rp_r];

endmodule

// ----- rtl/core/stp_back.sv -----
// Back end: holds the tile pattern state, scans active tile columns at block
// close into a result queue, then applies the item. Uses stp_pkg and the macros.
`include "assert_macros.svh"

module stp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [stp_pkg::DW-1:0]  eff_w,
  input  stp_pkg::q_sts_t         q_sts,
  input  stp_pkg::item_t          q_item,
  output logic                    q_pop,
  input  logic                    out_pop,
  output logic                    out_empty,
  output stp_pkg::res_t           out_res
);

  localparam int unsigned N = stp_pkg::MAX_TILE_COLS;
  localparam int unsigned W = stp_pkg::DW;

  stp_pkg::back_st_t      st_r, st_nxt;
  logic [N-1:0]           active_map_r;
  logic [N-1:0]           rem_map_r;
  logic [W-1:0]           block_row_start_r;
  logic [W:0]             block_min_r;
  logic [W-1:0]           block_min_base_r;
  logic [W:0]             prev_row_r;
  logic [W:0]             first_row_r [N];
  logic [stp_pkg::TCW-1:0] c_r;
  logic [W-1:0]           col_acc_r;

  stp_pkg::res_t          ofifo_r [stp_pkg::ODEPTH];
  logic [stp_pkg::OAW-1:0] owp_r, orp_r;
  logic [stp_pkg::OAW:0]  ocnt_r;
  logic                   ofull, opush, opop;

  logic                   need_close;
  logic                   scan_done;
  logic                   cur_bit;
  logic [N-1:0]           rem_cleared;
  logic                   do_apply;
  logic                   is_entry;
  logic [W-1:0]           base;
  logic [W-1:0]           band;
  stp_pkg::res_t          res;

  assign is_entry   = q_item.op == stp_pkg::OP_ENTRY;
  assign need_close = !is_entry ||
                      (prev_row_r != stp_pkg::NONE17 && q_item.brs != block_row_start_r);
  assign scan_done  = rem_map_r == '0;
  assign cur_bit    = rem_map_r[c_r];
  assign rem_cleared = rem_map_r & ~(N'(1) << c_r);
  assign ofull      = ocnt_r == (stp_pkg::OAW+1)'(stp_pkg::ODEPTH);
  assign opush      = (st_r == stp_pkg::B_SCAN) && !scan_done && cur_bit && !ofull;
  assign opop       = out_pop && (ocnt_r != '0);
  assign do_apply   = st_r == stp_pkg::B_APPLY;

  // Band start: block base, lowered, for tile columns other than column 0, to the column's first active block.
  always_comb begin
    base = (block_min_r != stp_pkg::NONE17) ? block_min_base_r : '0;
    band = base;
    if (c_r != '0 && first_row_r[c_r] < {1'b0, base}) begin
      band = first_row_r[c_r][W-1:0];
    end
    res.tile_row_start = block_row_start_r;
    res.tile_col_start = col_acc_r;
    res.band_start     = band;
    res.is_upper       = block_row_start_r <= col_acc_r;
    res.last_of_burst  = rem_cleared == '0;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      stp_pkg::B_IDLE: begin
        if (q_sts.valid) begin
          st_nxt = need_close ? stp_pkg::B_SCAN : stp_pkg::B_APPLY;
        end
      end
      stp_pkg::B_SCAN: begin
        if (scan_done) st_nxt = stp_pkg::B_APPLY;
      end
      stp_pkg::B_APPLY: st_nxt = stp_pkg::B_IDLE;
      default:          st_nxt = stp_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    case (st_r)
      stp_pkg::B_APPLY: q_pop = 1'b1;
      default:          q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= stp_pkg::B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Scan cursor: load on entry to the scan, advance past idle or emitted columns.
  always_ff @(posedge clk) begin
    if (st_r == stp_pkg::B_IDLE) begin
      rem_map_r <= active_map_r;
      c_r       <= '0;
      col_acc_r <= '0;
    end else if (st_r == stp_pkg::B_SCAN && !scan_done && (!cur_bit || !ofull)) begin
      rem_map_r <= rem_cleared;
      c_r       <= c_r + 1'b1;
      col_acc_r <= col_acc_r + eff_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_map_r      <= '0;
      block_row_start_r <= '0;
      block_min_r       <= stp_pkg::NONE17;
      prev_row_r        <= stp_pkg::NONE17;
    end else if (st_r == stp_pkg::B_SCAN && scan_done) begin
      active_map_r <= '0;
      block_min_r  <= stp_pkg::NONE17;
    end else if (do_apply) begin
      if (!is_entry) begin
        active_map_r      <= '0;
        block_row_start_r <= '0;
        block_min_r       <= stp_pkg::NONE17;
        prev_row_r        <= stp_pkg::NONE17;
      end else begin
        block_row_start_r <= q_item.brs;
        if ({1'b0, q_item.row} != prev_row_r) begin
          prev_row_r <= {1'b0, q_item.row};
          if ({1'b0, q_item.col} < block_min_r) begin
            block_min_r <= {1'b0, q_item.col};
          end
        end
        if (q_item.col != q_item.row) begin
          active_map_r <= active_map_r | (N'(1) << q_item.tc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_apply && is_entry && {1'b0, q_item.row} != prev_row_r &&
        {1'b0, q_item.col} < block_min_r) begin
      block_min_base_r <= q_item.col_base;
    end
  end

  // First active block per tile column: each entry compares its own slot.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (!rst_n || (do_apply && !is_entry)) begin
        first_row_r[i] <= stp_pkg::NONE17;
      end else if (do_apply && q_item.col != q_item.row &&
                   q_item.tc == stp_pkg::TCW'(i) && {1'b0, q_item.brs} < first_row_r[i]) begin
        first_row_r[i] <= {1'b0, q_item.brs};
      end
    end
  end

  // Result queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + 1'b1;
      if (opop)  orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + (stp_pkg::OAW+1)'(opush) - (stp_pkg::OAW+1)'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) ofifo_r[owp_r] <= res;
  end

  assign out_empty = ocnt_r == '0;
  assign out_res   = ofifo_r[orp_r];

  `STP_ASSERT(a_scan_has_item, (st_r == stp_pkg::B_SCAN) |-> q_sts.valid, "scan without item")
  `STP_NEVER(a_ofifo_ovf, opush && ofull, "result queue overflow")
  `STP_ASSERT(a_close_clears, (st_r == stp_pkg::B_SCAN && scan_done) |=> (active_map_r == '0), "map not cleared at close")

endmodule

// ----- rtl/core/sparse_tile_pattern_lower_upper_unit.sv -----
// Sparse tile pattern unit, lower/upper split: top level.
// Front: a nonzero is accepted, divided by the bit-serial dividers and then pushed to the queue.
// No new item is taken until the last is pushed or dropped; row and column each have their own serial divider.
// At a block close the back scans the tile columns up to the last active one,
// and a full result queue stalls the scan.
// Reset: synchronous active-low rst_n; registers return to 32, all pattern state clears.
module sparse_tile_pattern_lower_upper_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_operation,
  input  logic [stp_pkg::DW-1:0]  in_entry_row,
  input  logic [stp_pkg::DW-1:0]  in_entry_col,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [stp_pkg::DW-1:0]  out_tile_row_start,
  output logic [stp_pkg::DW-1:0]  out_tile_col_start,
  output logic [stp_pkg::DW-1:0]  out_band_start,
  output logic                    out_is_upper,
  output logic                    out_last_of_burst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [stp_pkg::DW-1:0]  cfg_data
);

  logic [stp_pkg::DW-1:0] tile_height_r;
  logic [stp_pkg::DW-1:0] tile_width_r;
  logic [stp_pkg::DW-1:0] eff_h, eff_w;
  stp_pkg::q_ctl_t        q_ctl;
  stp_pkg::q_sts_t        q_sts;
  stp_pkg::item_t         f_item, b_item;
  stp_pkg::res_t          res;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_height_r <= stp_pkg::DW'(32);
      tile_width_r  <= stp_pkg::DW'(32);
    end else if (cfg_valid) begin
      case (stp_pkg::reg_idx_t'(cfg_index))
        stp_pkg::REG_TILE_HEIGHT: tile_height_r <= cfg_data;
        stp_pkg::REG_TILE_WIDTH:  tile_width_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero tile size acts as one.
  assign eff_h = (tile_height_r == '0) ? stp_pkg::DW'(1) : tile_height_r;
  assign eff_w = (tile_width_r == '0)  ? stp_pkg::DW'(1) : tile_width_r;

  // Front: accept, divide, classify.
  stp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_entry_row(in_entry_row), .in_entry_col(in_entry_col),
    .eff_h(eff_h), .eff_w(eff_w),
    .q_sts(q_sts), .q_push(q_ctl.push), .q_item(f_item)
  );

  // Decouple front and back.
  stp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .ctl(q_ctl), .wr_item(f_item), .sts(q_sts), .rd_item(b_item)
  );

  // Back: hold pattern state, emit tiles at block close.
  stp_back u_back (
    .clk(clk), .rst_n(rst_n), .eff_w(eff_w),
    .q_sts(q_sts), .q_item(b_item), .q_pop(q_ctl.pop),
    .out_pop(out_pop), .out_empty(out_empty), .out_res(res)
  );

  assign out_tile_row_start = res.tile_row_start;
  assign out_tile_col_start = res.tile_col_start;
  assign out_band_start     = res.band_start;
  assign out_is_upper       = res.is_upper;
  assign out_last_of_burst  = res.last_of_burst;

endmodule
